// File: hw/rtl/pse_pkg.sv
// Shared types, field widths and command/status codes for the positional stack engine.
package pse_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int WORD_WIDTH_DEF = 32;

	localparam int CMD_W   = 3;
	localparam int POS_W   = 5;
	localparam int CNT_W   = 5;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;

	localparam int IN_DATA_W  = 48;
	localparam int IN_USER_W  = CMD_W;
	localparam int OUT_DATA_W = 16;

	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_ERR  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [POS_W-1:0]   position;
		logic [CNT_W-1:0]   count;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              found;
		logic [POS_W-1:0]  found_position;
		logic [POS_W-1:0]  occupancy;
	} res_t;

endpackage

// File: hw/rtl/pse_mem.sv
// Entry storage: one write port, one read port with registered read data.
module pse_mem #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32,
	parameter int AW         = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WORD_WIDTH-1:0] wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [WORD_WIDTH-1:0] rdata
);

	logic [WORD_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/pse_seq.sv
// Command sequencer: decodes a command and walks the entry memory one word per cycle.
module pse_seq
	import pse_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  cmd_t                                 cmd,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output res_t                                 res,
	output logic                                 mem_we,
	output logic [$clog2(DEPTH)-1:0]             mem_waddr,
	output logic [WORD_WIDTH-1:0]                mem_wdata,
	output logic                                 mem_re,
	output logic [$clog2(DEPTH)-1:0]             mem_raddr,
	input  logic [WORD_WIDTH-1:0]                mem_rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	typedef enum logic [1:0] {IDLE, MOVE, SEARCH, DONE} state_t;

	state_t              state_q;
	logic [CW-1:0]       n_q;
	logic [WORD_WIDTH-1:0] val_q;
	logic                ins_q;
	logic                up_q;
	logic [AW-1:0]       at_q;
	logic [CW-1:0]       moves_q;
	logic [CW-1:0]       off_q;
	logic [AW-1:0]       src_q;
	logic [CW-1:0]       left_q;
	logic [CW-1:0]       idx_q;
	logic                pend_s1;
	logic [AW-1:0]       dst_s1;
	logic [CW-1:0]       idx_s1;
	logic [STAT_W-1:0]   status_q;
	logic                found_q;
	logic [CW-1:0]       fpos_q;

	logic                  start;
	logic [WORD_WIDTH+VALUE_W-1:0] val_x;
	logic [WORD_WIDTH-1:0] val_in;
	logic [XW-1:0]         n_x, pos_x, cnt_x, at_x, avail_x, rem_x, src_x, dst_x, fpos_x;
	logic                  full, ins_ok, del_ok, issue, match;

	assign start    = in_valid && in_ready;
	assign in_ready = (state_q == IDLE);

	assign val_x   = {{WORD_WIDTH{1'b0}}, cmd.value};
	assign val_in  = val_x[WORD_WIDTH-1:0];
	assign n_x     = XW'(n_q);
	assign pos_x   = XW'(cmd.position);
	assign cnt_x   = XW'(cmd.count);
	assign full    = (n_x == XW'(DEPTH));
	assign ins_ok  = (pos_x != '0) && (pos_x <= n_x + XW'(1));
	assign del_ok  = (pos_x != '0) && (pos_x <= n_x);
	assign at_x    = n_x + XW'(1) - pos_x;
	assign avail_x = n_x - pos_x + XW'(1);
	assign rem_x   = (cnt_x < avail_x) ? cnt_x : avail_x;
	assign src_x   = XW'(src_q);
	assign dst_x   = up_q ? (src_x - XW'(off_q)) : (src_x + XW'(1));
	assign issue   = (state_q == MOVE) ? (moves_q != '0) : (left_q != '0);
	assign match   = pend_s1 && (mem_rdata == val_q);
	assign fpos_x  = XW'(fpos_q);

	assign res_valid = (state_q == DONE);
	assign res = '{status: status_q, found: found_q,
		found_position: fpos_x[POS_W-1:0], occupancy: n_x[POS_W-1:0]};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = dst_s1;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = src_q;
		unique case (state_q)
			IDLE: begin
				if (start && cmd.command == CMD_PUSH && !full) begin
					mem_we    = 1'b1;
					mem_waddr = n_x[AW-1:0];
					mem_wdata = val_in;
				end
			end
			MOVE: begin
				mem_re = issue;
				if (pend_s1) begin
					mem_we = 1'b1;
				end else if (!issue && ins_q) begin
					mem_we    = 1'b1;
					mem_waddr = at_q;
					mem_wdata = val_q;
				end
			end
			SEARCH: mem_re = issue;
			DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			n_q      <= '0;
			val_q    <= '0;
			ins_q    <= 1'b0;
			up_q     <= 1'b0;
			at_q     <= '0;
			off_q    <= '0;
			src_q    <= '0;
			idx_q    <= '0;
			dst_s1   <= '0;
			idx_s1   <= '0;
			pend_s1  <= 1'b0;
			status_q <= ST_OK;
			found_q  <= 1'b0;
			fpos_q   <= '0;
			moves_q  <= '0;
			left_q   <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					pend_s1 <= 1'b0;
					if (start) begin
						status_q <= ST_OK;
						found_q  <= 1'b0;
						fpos_q   <= '0;
						val_q    <= val_in;
						unique case (cmd.command)
							CMD_PUSH: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									n_q <= n_q + CW'(1);
								end
								state_q <= DONE;
							end
							CMD_POP: begin
								if (n_q == '0) begin
									status_q <= ST_ERR;
								end else begin
									n_q <= n_q - CW'(1);
								end
								state_q <= DONE;
							end
							CMD_INSERT: begin
								if (full) begin
									status_q <= ST_FULL;
									state_q  <= DONE;
								end else if (!ins_ok) begin
									status_q <= ST_ERR;
									state_q  <= DONE;
								end else begin
									ins_q   <= 1'b1;
									up_q    <= 1'b0;
									at_q    <= at_x[AW-1:0];
									moves_q <= CW'(pos_x - XW'(1));
									src_q   <= AW'(n_x - XW'(1));
									n_q     <= n_q + CW'(1);
									state_q <= MOVE;
								end
							end
							CMD_DELETE: begin
								if (!del_ok) begin
									status_q <= ST_ERR;
									state_q  <= DONE;
								end else begin
									ins_q   <= 1'b0;
									up_q    <= 1'b1;
									off_q   <= rem_x[CW-1:0];
									moves_q <= CW'(pos_x - XW'(1));
									src_q   <= avail_x[AW-1:0];
									n_q     <= CW'(n_x - rem_x);
									state_q <= MOVE;
								end
							end
							CMD_SEARCH: begin
								src_q   <= AW'(n_x - XW'(1));
								left_q  <= n_q;
								idx_q   <= CW'(1);
								state_q <= SEARCH;
							end
							default: begin
								status_q <= ST_ERR;
								state_q  <= DONE;
							end
						endcase
					end
				end
				MOVE: begin
					pend_s1 <= issue;
					if (issue) begin
						moves_q <= moves_q - CW'(1);
						src_q   <= up_q ? (src_q + AW'(1)) : (src_q - AW'(1));
						dst_s1  <= dst_x[AW-1:0];
					end
					if (!issue && !pend_s1) begin
						state_q <= DONE;
					end
				end
				SEARCH: begin
					pend_s1 <= issue;
					if (issue) begin
						left_q <= left_q - CW'(1);
						src_q  <= src_q - AW'(1);
						idx_s1 <= idx_q;
						idx_q  <= idx_q + CW'(1);
					end
					if (match) begin
						found_q <= 1'b1;
						fpos_q  <= idx_s1;
						state_q <= DONE;
					end else if (!issue) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					pend_s1 <= 1'b0;
					if (res_ready) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/positional_stack_engine.sv
// Top level of the positional stack engine: stream ports, output register, sequencer and storage.
//
// Bounded stack of DEPTH words with push, pop, insert at a position from the top, delete of a
// run starting at a position, and search; every command returns one status word. One command
// is in flight at a time. Insert and delete move one word at a time and search compares one
// word at a time, each on the single memory read port. The result sits in an output register,
// so the next command is taken once the sequencer has handed its result over.
module positional_stack_engine
	import pse_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // position[4:0], count[9:5], value[41:10], zero pad
	input  logic [IN_USER_W-1:0]  s_tuser,   // command[2:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // status[1:0], found[2], found_position[7:3],
	                                         // occupancy[12:8], zero pad
);

	localparam int AW = $clog2(DEPTH);

	cmd_t                  cmd;
	res_t                  res;
	res_t                  out_q;
	logic                  out_valid_q;
	logic                  res_valid, res_ready;
	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_waddr, mem_raddr;
	logic [WORD_WIDTH-1:0] mem_wdata, mem_rdata;

	assign cmd = '{command: s_tuser,
		position: s_tdata[POS_W-1:0],
		count:    s_tdata[POS_W+CNT_W-1:POS_W],
		value:    s_tdata[POS_W+CNT_W+VALUE_W-1:POS_W+CNT_W]};

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({out_q.occupancy, out_q.found_position, out_q.found,
		out_q.status});

	pse_seq #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	pse_mem #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH),
		.AW         (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// File: hw/rtl/pse_chk.sv
// Port-level checker for the positional stack engine, bound to the top level.
module pse_chk
	import pse_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// stalled result word must hold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// one command at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command taken while busy");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("undefined status code");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == ST_OK && m_tdata[7:3] != 5'd0)
		else $error("match without ok status or position");

	a_nofound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[7:3] == 5'd0)
		else $error("match position without match");

endmodule

bind positional_stack_engine pse_chk u_pse_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
